// ===== rtl/pl0ts_pkg.sv =====
`timescale 1ns / 1ps
// pl0ts_pkg: payload types, token and error codes, the reserved-word table and
// the result builders shared by the PL/0 token scanner. No dependencies.
package pl0ts_pkg;

  // Limits of the token scanner.
  localparam int MAX_IDENT_CHARS = 11;
  localparam int MAX_DIGITS      = 5;
  localparam int NAME_CHARS      = 11;
  localparam int NUM_WORDS       = 10;
  localparam int WORD_CHARS      = 9;
  localparam int MAX_RESULTS     = 3;
  localparam int RES_CW          = $clog2(MAX_RESULTS + 1);

  // Result queue geometry.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int CNT_W    = RQ_AW + 1;
  localparam logic [CNT_W-1:0] RQ_FULL = CNT_W'(RQ_DEPTH);

  // Token kinds.
  localparam logic [5:0] KIND_END       = 6'd0;
  localparam logic [5:0] KIND_IDENT     = 6'd1;
  localparam logic [5:0] KIND_NUMBER    = 6'd2;
  localparam logic [5:0] KIND_WORD_BASE = 6'd3;
  localparam logic [5:0] KIND_PERIOD    = 6'd13;
  localparam logic [5:0] KIND_LBRACK    = 6'd14;
  localparam logic [5:0] KIND_RBRACK    = 6'd15;
  localparam logic [5:0] KIND_COMMA     = 6'd16;
  localparam logic [5:0] KIND_SEMI      = 6'd17;
  localparam logic [5:0] KIND_BECOMES   = 6'd18;
  localparam logic [5:0] KIND_COLON     = 6'd19;
  localparam logic [5:0] KIND_QUERY     = 6'd20;
  localparam logic [5:0] KIND_LPAREN    = 6'd21;
  localparam logic [5:0] KIND_RPAREN    = 6'd22;
  localparam logic [5:0] KIND_NEQ       = 6'd23;
  localparam logic [5:0] KIND_LEQ       = 6'd24;
  localparam logic [5:0] KIND_LSS       = 6'd25;
  localparam logic [5:0] KIND_GEQ       = 6'd26;
  localparam logic [5:0] KIND_GTR       = 6'd27;
  localparam logic [5:0] KIND_PERCENT   = 6'd28;
  localparam logic [5:0] KIND_SLASH     = 6'd29;
  localparam logic [5:0] KIND_TIMES     = 6'd30;
  localparam logic [5:0] KIND_MINUS     = 6'd31;
  localparam logic [5:0] KIND_PLUS      = 6'd32;
  localparam logic [5:0] KIND_EQL       = 6'd33;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_LETTER     = 3'd1;
  localparam logic [2:0] ERR_NUM_LONG   = 3'd2;
  localparam logic [2:0] ERR_IDENT_LONG = 3'd3;
  localparam logic [2:0] ERR_SYMBOL     = 3'd4;

  // Reserved words; string literals are right-justified, so the first
  // character sits in the highest used byte.
  localparam logic [WORD_CHARS*8-1:0] WORD_TEXT [NUM_WORDS] = '{
    "var", "procedure", "call", "begin", "end",
    "if", "do", "read", "write", "while"
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [16:0] number_value;
    logic [63:0] name_low;
    logic [23:0] name_high;
    logic [3:0]  name_length;
    logic [2:0]  error_code;
    logic        last_result;
  } out_t;

  // Everything one source byte produces, in order.
  typedef struct packed {
    logic [RES_CW-1:0]           count;
    out_t [MAX_RESULTS-1:0]      res;
  } step_t;

  typedef logic [NAME_CHARS-1:0][7:0] name_t;

  // Result without name characters.
  function automatic out_t plain_result(input logic [5:0] kind, input logic [16:0] value,
                                        input logic [2:0] err);
    out_t r;
    r              = '0;
    r.token_kind   = kind;
    r.number_value = value;
    r.error_code   = err;
    return r;
  endfunction

  // Close an identifier: a reserved word, or a plain identifier with its name.
  function automatic out_t word_result(input name_t store, input logic [3:0] cnt);
    out_t       r;
    logic       hit;
    logic       match;
    logic [3:0] len;
    name_t      nm;
    r   = '0;
    hit = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      match = (cnt == WORD_LEN[w]);
      for (int i = 0; i < WORD_CHARS; i++) begin
        if (i < int'(WORD_LEN[w])) begin
          match = match & (store[i] == WORD_TEXT[w][8*(int'(WORD_LEN[w])-1-i) +: 8]);
        end
      end
      if (match && !hit) begin
        hit          = 1'b1;
        r.token_kind = KIND_WORD_BASE + 6'(w);
      end
    end
    len = (cnt > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : cnt;
    for (int i = 0; i < NAME_CHARS; i++) begin
      nm[i] = (4'(i) < len) ? store[i] : 8'h00;
    end
    if (!hit) begin
      r.token_kind  = KIND_IDENT;
      r.name_low    = nm[7:0];
      r.name_high   = nm[10:8];
      r.name_length = len;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pl0ts_scan.sv =====
`timescale 1ns / 1ps
// pl0ts_scan: scanner state registers and the single-pass step logic that
// turns one source byte into up to three results. Uses pl0ts_pkg.
module pl0ts_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pl0ts_pkg::in_t   item_i,
  input  logic             go_i,
  output pl0ts_pkg::step_t step_o
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_SYMBOL  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // One-character symbols that need no lookahead; KIND_END means none.
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h2E:   k = pl0ts_pkg::KIND_PERIOD;
      8'h5B:   k = pl0ts_pkg::KIND_LBRACK;
      8'h5D:   k = pl0ts_pkg::KIND_RBRACK;
      8'h2C:   k = pl0ts_pkg::KIND_COMMA;
      8'h3B:   k = pl0ts_pkg::KIND_SEMI;
      8'h3F:   k = pl0ts_pkg::KIND_QUERY;
      8'h28:   k = pl0ts_pkg::KIND_LPAREN;
      8'h29:   k = pl0ts_pkg::KIND_RPAREN;
      8'h25:   k = pl0ts_pkg::KIND_PERCENT;
      8'h2A:   k = pl0ts_pkg::KIND_TIMES;
      8'h2D:   k = pl0ts_pkg::KIND_MINUS;
      8'h2B:   k = pl0ts_pkg::KIND_PLUS;
      default: k = pl0ts_pkg::KIND_END;
    endcase
    return k;
  endfunction

  // Kind of a symbol that closes without its second character.
  function automatic logic [5:0] lone_kind(input logic [7:0] p);
    logic [5:0] k;
    unique case (p)
      CH_COLON: k = pl0ts_pkg::KIND_COLON;
      CH_LT:    k = pl0ts_pkg::KIND_LSS;
      CH_GT:    k = pl0ts_pkg::KIND_GTR;
      CH_SLASH: k = pl0ts_pkg::KIND_SLASH;
      default:  k = pl0ts_pkg::KIND_END;
    endcase
    return k;
  endfunction

  logic [2:0]                    mode_q, mode_d;
  pl0ts_pkg::name_t              store_q, store_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [16:0]                   acc_q, acc_d;
  logic [7:0]                    pend_q, pend_d;
  logic                          drain_q, drain_d;

  pl0ts_pkg::out_t [pl0ts_pkg::MAX_RESULTS-1:0] res_v;
  logic [pl0ts_pkg::RES_CW-1:0]  n_v;
  logic                          failed;
  logic                          fresh;
  logic                          last;
  logic [7:0]                    c;
  logic                          is_alpha, is_digit, is_skip;
  logic [5:0]                    kind_v;

  assign c        = item_i.ch;
  assign last     = item_i.last_char;
  assign is_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_skip  = (c <= CH_SPACE) || (c == CH_DEL);

  always_comb begin
    mode_d  = mode_q;
    store_d = store_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    drain_d = drain_q;
    res_v   = '0;
    n_v     = '0;
    failed  = 1'b0;
    fresh   = 1'b0;
    kind_v  = pl0ts_pkg::KIND_END;

    if (drain_q) begin
      // drop bytes after an error; the last byte re-arms
      if (last) begin
        drain_d = 1'b0;
      end
    end else begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_alpha || is_digit) begin
            if ((cnt_q >= 4'(pl0ts_pkg::MAX_IDENT_CHARS)) ||
                (cnt_q >= 4'(pl0ts_pkg::NAME_CHARS))) begin
              res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0,
                                                   pl0ts_pkg::ERR_IDENT_LONG);
              n_v    = n_v + 1'b1;
              failed = 1'b1;
            end else begin
              store_d[cnt_q] = c;
              cnt_d          = cnt_q + 4'd1;
            end
          end else begin
            res_v[n_v] = pl0ts_pkg::word_result(store_q, cnt_q);
            n_v        = n_v + 1'b1;
            fresh      = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            if (cnt_q >= 4'(pl0ts_pkg::MAX_DIGITS)) begin
              res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0,
                                                   pl0ts_pkg::ERR_NUM_LONG);
              n_v    = n_v + 1'b1;
              failed = 1'b1;
            end else begin
              acc_d = acc_q * 17'd10 + {13'd0, c[3:0]};
              cnt_d = cnt_q + 4'd1;
            end
          end else if (is_alpha) begin
            res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0,
                                                 pl0ts_pkg::ERR_LETTER);
            n_v    = n_v + 1'b1;
            failed = 1'b1;
          end else begin
            res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_NUMBER, acc_q,
                                                 pl0ts_pkg::ERR_NONE);
            n_v   = n_v + 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_SYMBOL: begin
          if ((pend_q == CH_COLON) && (c == CH_EQ)) begin
            kind_v = pl0ts_pkg::KIND_BECOMES;
          end else if ((pend_q == CH_LT) && (c == CH_GT)) begin
            kind_v = pl0ts_pkg::KIND_NEQ;
          end else if ((pend_q == CH_LT) && (c == CH_EQ)) begin
            kind_v = pl0ts_pkg::KIND_LEQ;
          end else if ((pend_q == CH_GT) && (c == CH_EQ)) begin
            kind_v = pl0ts_pkg::KIND_GEQ;
          end else if ((pend_q == CH_EQ) && (c == CH_EQ)) begin
            kind_v = pl0ts_pkg::KIND_EQL;
          end
          if (kind_v != pl0ts_pkg::KIND_END) begin
            res_v[n_v] = pl0ts_pkg::plain_result(kind_v, '0, pl0ts_pkg::ERR_NONE);
            n_v        = n_v + 1'b1;
          end else if ((pend_q == CH_SLASH) && (c == CH_SLASH)) begin
            mode_d = MODE_COMMENT;
          end else if ((pend_q == CH_EQ) || (lone_kind(pend_q) == pl0ts_pkg::KIND_END)) begin
            res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0,
                                                 pl0ts_pkg::ERR_SYMBOL);
            n_v    = n_v + 1'b1;
            failed = 1'b1;
          end else begin
            res_v[n_v] = pl0ts_pkg::plain_result(lone_kind(pend_q), '0,
                                                 pl0ts_pkg::ERR_NONE);
            n_v   = n_v + 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if ((c == CH_CR) || (c == CH_LF)) begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // a closed token clears the token state
      if (failed || (mode_q == MODE_IDENT && fresh) || (mode_q == MODE_NUMBER && fresh) ||
          (mode_q == MODE_SYMBOL)) begin
        if (!(mode_q == MODE_SYMBOL && mode_d == MODE_COMMENT)) begin
          mode_d = MODE_IDLE;
        end
        cnt_d  = '0;
        acc_d  = '0;
        pend_d = '0;
      end

      // scan the byte as the start of a new token
      if (fresh) begin
        if (is_skip) begin
          mode_d = mode_d;
        end else if (is_alpha) begin
          mode_d     = MODE_IDENT;
          store_d[0] = c;
          cnt_d      = 4'd1;
        end else if (is_digit) begin
          mode_d = MODE_NUMBER;
          acc_d  = {13'd0, c[3:0]};
          cnt_d  = 4'd1;
        end else if ((c == CH_COLON) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) ||
                     (c == CH_SLASH)) begin
          mode_d = MODE_SYMBOL;
          pend_d = c;
        end else if (single_kind(c) != pl0ts_pkg::KIND_END) begin
          res_v[n_v] = pl0ts_pkg::plain_result(single_kind(c), '0, pl0ts_pkg::ERR_NONE);
          n_v        = n_v + 1'b1;
        end else begin
          res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0,
                                               pl0ts_pkg::ERR_SYMBOL);
          n_v    = n_v + 1'b1;
          failed = 1'b1;
          mode_d = MODE_IDLE;
          cnt_d  = '0;
          acc_d  = '0;
          pend_d = '0;
        end
      end

      if (failed) begin
        drain_d = !last;
      end else if (last) begin
        // flush the token left open by this byte, then the end token unless the flush failed
        unique case (mode_d)
          MODE_IDENT: begin
            res_v[n_v] = pl0ts_pkg::word_result(store_d, cnt_d);
            n_v        = n_v + 1'b1;
          end
          MODE_NUMBER: begin
            res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_NUMBER, acc_d,
                                                 pl0ts_pkg::ERR_NONE);
            n_v        = n_v + 1'b1;
          end
          MODE_SYMBOL: begin
            if (lone_kind(pend_d) != pl0ts_pkg::KIND_END) begin
              res_v[n_v] = pl0ts_pkg::plain_result(lone_kind(pend_d), '0,
                                                   pl0ts_pkg::ERR_NONE);
            end else begin
              res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0,
                                                   pl0ts_pkg::ERR_SYMBOL);
              failed     = 1'b1;
            end
            n_v = n_v + 1'b1;
          end
          default: begin
            n_v = n_v;
          end
        endcase
        if (!failed) begin
          res_v[n_v] = pl0ts_pkg::plain_result(pl0ts_pkg::KIND_END, '0, pl0ts_pkg::ERR_NONE);
          n_v        = n_v + 1'b1;
        end
        mode_d = MODE_IDLE;
        cnt_d  = '0;
        acc_d  = '0;
        pend_d = '0;
      end

      if (n_v != '0) begin
        res_v[n_v - 1'b1].last_result = 1'b1;
      end
    end
  end

  assign step_o.count = n_v;
  assign step_o.res   = res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      pend_q  <= '0;
      drain_q <= 1'b0;
    end else if (go_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      drain_q <= drain_d;
    end
  end

  // name characters: only entries below the count affect a result
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      store_q <= store_d;
    end
  end

endmodule

// ===== rtl/pl0ts_rqueue.sv =====
`timescale 1ns / 1ps
// pl0ts_rqueue: four-entry result queue, up to three entries written per
// cycle, one read per output transfer. Uses pl0ts_pkg.
module pl0ts_rqueue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  pl0ts_pkg::step_t              step_i,
  output logic [pl0ts_pkg::CNT_W-1:0]   free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pl0ts_pkg::out_t               out_data_o
);

  pl0ts_pkg::out_t                 ent_q [pl0ts_pkg::RQ_DEPTH];
  logic [pl0ts_pkg::RQ_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [pl0ts_pkg::RQ_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [pl0ts_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [pl0ts_pkg::CNT_W-1:0]     push_n;
  logic                            pop;

  assign push_n = push_i ?
                  {{(pl0ts_pkg::CNT_W - pl0ts_pkg::RES_CW){1'b0}}, step_i.count} : '0;
  assign pop    = out_valid_o && !out_stall_i;

  assign wr_ptr_d = wr_ptr_q + push_n[pl0ts_pkg::RQ_AW-1:0];
  assign rd_ptr_d = rd_ptr_q + {{(pl0ts_pkg::RQ_AW-1){1'b0}}, pop};
  assign cnt_d    = cnt_q + push_n - {{(pl0ts_pkg::CNT_W-1){1'b0}}, pop};

  assign free_o      = pl0ts_pkg::RQ_FULL - cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int k = 0; k < pl0ts_pkg::MAX_RESULTS; k++) begin
        if (k < int'(step_i.count)) begin
          ent_q[wr_ptr_q + k[pl0ts_pkg::RQ_AW-1:0]] <= step_i.res[k];
        end
      end
    end
  end

endmodule

// ===== rtl/pl0_token_scanner_core.sv =====
`timescale 1ns / 1ps
// pl0_token_scanner_core: top level of the PL/0 token scanner.
// Instantiates pl0ts_scan and pl0ts_rqueue; uses pl0ts_pkg.

// Source bytes enter on the input channel, one per transfer, with last_char
// set on the final byte of a text; tokens leave on the output channel, one
// per transfer, with last_result set on the final result caused by a byte.
// A byte is held in an input register, stepped through the combinational
// scanner logic (up to three results: the token it closes, a one-character
// symbol it forms, and the end token when it is the last byte) and the
// results land in a four-entry queue. A byte is therefore taken every cycle
// as long as the queue can hold the results it will produce, and a byte that
// yields no result (space, comment text) still passes the input register.
// A byte moves from the input register into the queue once the queue has
// room for all its results, behind any results already queued. Sustained
// throughput is one byte per cycle, bounded by the output side at one
// result per cycle while the receiver does not stall, so the results of
// one byte leave one at a time. After an error one error result is given
// and bytes are dropped up to and including the next byte marked last.
module pl0_token_scanner_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pl0ts_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pl0ts_pkg::out_t out_data_o
);

  logic                         in_vld_q, in_vld_d;
  pl0ts_pkg::in_t               in_q;
  logic                         in_take;
  logic                         go;
  pl0ts_pkg::step_t             step;
  logic [pl0ts_pkg::CNT_W-1:0]  free;
  logic [pl0ts_pkg::CNT_W-1:0]  need;

  // Step the held byte only when every result it makes fits in the queue.
  assign need = {{(pl0ts_pkg::CNT_W - pl0ts_pkg::RES_CW){1'b0}}, step.count};
  assign go   = in_vld_q && (need <= free);

  // Hold the input register while its byte waits for queue room.
  assign in_stall_o = in_vld_q && !go;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take || (in_vld_q && !go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  pl0ts_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .go_i   (go),
    .step_o (step)
  );

  pl0ts_rqueue u_rqueue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (go),
    .step_i      (step),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for pl0_token_scanner_core, fed source text byte by byte.
// Depends on pl0ts_pkg for the payload structs and the token and error codes.
module tb_top;
  import pl0ts_pkg::*;

  // Bench limits: cycles without any transfer before the run is declared hung,
  // length of the long receiver hold-off, and bytes per random phase.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_BYTES  = 75;
  localparam int NUM_KEYWORDS = 10;
  localparam int NUM_SYMBOLS  = 22;
  localparam int NUM_PROBES   = 24;

  // Scanner modes as the predictor tracks them.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SYMBOL  = 3'd3,
    MODE_COMMENT = 3'd4
  } scan_mode_e;

  // One row of the directed table; kind and err are the single token the row
  // must give when typed is set, otherwise the predictor decides.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [5:0] kind;
    logic [2:0] err;
  } probe_t;

  localparam probe_t PROBE_TAB [NUM_PROBES] = '{
    '{8'h01, 1'b0, 1'b0, KIND_END,       ERR_NONE},    // control byte, skipped
    '{".",   1'b0, 1'b1, KIND_PERIOD,    ERR_NONE},
    '{":",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"=",   1'b0, 1'b1, KIND_BECOMES,   ERR_NONE},
    '{"<",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{">",   1'b0, 1'b1, KIND_NEQ,       ERR_NONE},
    '{"=",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"x",   1'b0, 1'b1, KIND_END,       ERR_SYMBOL},  // lone '=' eats the x
    '{"a",   1'b0, 1'b0, KIND_END,       ERR_NONE},    // dropped after error
    '{"b",   1'b1, 1'b0, KIND_END,       ERR_NONE},    // last byte re-arms
    '{"v",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"a",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"r",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{" ",   1'b0, 1'b1, KIND_WORD_BASE, ERR_NONE},    // reserved word "var"
    '{"1",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"a",   1'b0, 1'b1, KIND_END,       ERR_LETTER},
    '{8'hFF, 1'b1, 1'b0, KIND_END,       ERR_NONE},    // dropped, re-arms
    '{8'hFF, 1'b0, 1'b1, KIND_END,       ERR_SYMBOL},  // top byte is unknown
    '{";",   1'b1, 1'b0, KIND_END,       ERR_NONE},    // dropped, re-arms
    '{"/",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"/",   1'b0, 1'b0, KIND_END,       ERR_NONE},
    '{"z",   1'b1, 1'b1, KIND_END,       ERR_NONE},    // comment runs into the end
    '{"7",   1'b1, 1'b0, KIND_END,       ERR_NONE},    // number, then end token
    '{"=",   1'b1, 1'b1, KIND_END,       ERR_SYMBOL}   // lone '=' at end of text
  };

  string kw_text [NUM_KEYWORDS] = '{
    "var", "procedure", "call", "begin", "end",
    "if", "do", "read", "write", "while"
  };
  string sym_text [NUM_SYMBOLS] = '{
    ".", "[", "]", ",", ";", ":=", ":", "?", "(", ")", "<>",
    "<=", "<", ">=", ">", "%", "/", "*", "-", "+", "==", "="
  };

  // Bench-driven signals start known at time zero.
  logic clk;
  logic rst_n      = 1'b0;
  logic byte_valid = 1'b0;
  logic byte_stall;
  in_t  byte_data  = '0;
  logic tok_valid;
  logic tok_stall  = 1'b0;
  out_t tok_data;

  pl0_token_scanner_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (byte_valid),
    .in_stall_o  (byte_stall),
    .in_data_i   (byte_data),
    .out_valid_o (tok_valid),
    .out_stall_i (tok_stall),
    .out_data_o  (tok_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor: its own copy of the scanner state.
  // ---------------------------------------------------------------------------
  scan_mode_e  pr_mode;
  logic [7:0]  pr_chars [NAME_CHARS];
  int unsigned pr_count;
  logic [16:0] pr_value;
  logic [7:0]  pr_sym;
  bit          pr_drop;    // dropping bytes up to the last one after an error
  bit          pr_fault;   // an error was raised by the current byte

  out_t byte_tokens [$];   // tokens the current byte gives, in order
  out_t tokens_due  [$];   // tokens still owed by the block
  bit   typed_flag_q [$];  // per offered byte: does a typed token replace the prediction
  out_t typed_tok_q  [$];

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_token(logic [5:0] kind, logic [16:0] val, bit named,
                                    logic [2:0] err);
    out_t        r;
    int unsigned len;
    if (byte_tokens.size() >= MAX_RESULTS) return;
    r              = '0;
    r.token_kind   = kind;
    r.number_value = val;
    r.error_code   = err;
    if (named) begin
      len = (pr_count > NAME_CHARS) ? NAME_CHARS : pr_count;
      for (int i = 0; i < len; i++) begin
        if (i < 8) r.name_low[8*i +: 8] = pr_chars[i];
        else r.name_high[8*(i-8) +: 8] = pr_chars[i];
      end
      r.name_length = len[3:0];
    end
    byte_tokens.push_back(r);
  endfunction

  function automatic void add_sym(logic [5:0] kind);
    add_token(kind, '0, 1'b0, ERR_NONE);
  endfunction

  function automatic void clear_token();
    pr_mode  = MODE_IDLE;
    pr_count = 0;
    pr_value = '0;
    pr_sym   = '0;
  endfunction

  function automatic void raise_error(logic [2:0] err);
    add_token(KIND_END, '0, 1'b0, err);
    clear_token();
    pr_fault = 1'b1;
  endfunction

  // Close an identifier: a reserved word by its kind, otherwise with its name.
  function automatic void close_word();
    bit hit;
    bit same;
    hit = 1'b0;
    for (int w = 0; w < NUM_KEYWORDS; w++) begin
      same = (pr_count == kw_text[w].len());
      for (int i = 0; i < kw_text[w].len(); i++) begin
        if (same && pr_chars[i] != kw_text[w][i]) same = 1'b0;
      end
      if (same && !hit) begin
        hit = 1'b1;
        add_sym(KIND_WORD_BASE + 6'(w));
      end
    end
    if (!hit) add_token(KIND_IDENT, '0, 1'b1, ERR_NONE);
    clear_token();
  endfunction

  function automatic void close_number();
    add_token(KIND_NUMBER, pr_value, 1'b0, ERR_NONE);
    clear_token();
  endfunction

  // Scan a byte from the idle mode.
  function automatic void start_token(logic [7:0] c);
    if (c <= 8'h20 || c == 8'h7F) return;
    if (is_letter(c)) begin
      pr_mode     = MODE_IDENT;
      pr_chars[0] = c;
      pr_count    = 1;
      return;
    end
    if (is_digit(c)) begin
      pr_mode  = MODE_NUMBER;
      pr_value = 17'(c - "0");
      pr_count = 1;
      return;
    end
    case (c)
      ":", "<", ">", "=", "/": begin
        pr_mode = MODE_SYMBOL;
        pr_sym  = c;
      end
      ".":     add_sym(KIND_PERIOD);
      "[":     add_sym(KIND_LBRACK);
      "]":     add_sym(KIND_RBRACK);
      ",":     add_sym(KIND_COMMA);
      ";":     add_sym(KIND_SEMI);
      "?":     add_sym(KIND_QUERY);
      "(":     add_sym(KIND_LPAREN);
      ")":     add_sym(KIND_RPAREN);
      "%":     add_sym(KIND_PERCENT);
      "*":     add_sym(KIND_TIMES);
      "-":     add_sym(KIND_MINUS);
      "+":     add_sym(KIND_PLUS);
      default: raise_error(ERR_SYMBOL);
    endcase
  endfunction

  // A pending symbol that the next byte does not join stands alone.
  function automatic void close_symbol();
    logic [7:0] p;
    p = pr_sym;
    clear_token();
    case (p)
      ":":     add_sym(KIND_COLON);
      "<":     add_sym(KIND_LSS);
      ">":     add_sym(KIND_GTR);
      "/":     add_sym(KIND_SLASH);
      default: raise_error(ERR_SYMBOL);
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] c);
    case (pr_mode)
      MODE_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          if (pr_count >= MAX_IDENT_CHARS) raise_error(ERR_IDENT_LONG);
          else begin
            pr_chars[pr_count] = c;
            pr_count++;
          end
        end else begin
          close_word();
          start_token(c);
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          if (pr_count >= MAX_DIGITS) raise_error(ERR_NUM_LONG);
          else begin
            pr_value = 17'(pr_value * 17'd10 + 17'(c - "0"));
            pr_count++;
          end
        end else if (is_letter(c)) begin
          raise_error(ERR_LETTER);
        end else begin
          close_number();
          start_token(c);
        end
      end
      MODE_SYMBOL: begin
        if (pr_sym == ":" && c == "=") begin
          clear_token();
          add_sym(KIND_BECOMES);
        end else if (pr_sym == "<" && c == ">") begin
          clear_token();
          add_sym(KIND_NEQ);
        end else if (pr_sym == "<" && c == "=") begin
          clear_token();
          add_sym(KIND_LEQ);
        end else if (pr_sym == ">" && c == "=") begin
          clear_token();
          add_sym(KIND_GEQ);
        end else if (pr_sym == "=" && c == "=") begin
          clear_token();
          add_sym(KIND_EQL);
        end else if (pr_sym == "/" && c == "/") begin
          clear_token();
          pr_mode = MODE_COMMENT;
        end else if (pr_sym == "=") begin
          raise_error(ERR_SYMBOL);
        end else begin
          close_symbol();
          if (!pr_fault) start_token(c);
        end
      end
      MODE_COMMENT: begin
        if (c == 8'h0D || c == 8'h0A) pr_mode = MODE_IDLE;
      end
      default: start_token(c);
    endcase
  endfunction

  // Work out every token one accepted byte gives, into byte_tokens.
  function automatic void predict_tokens(in_t d);
    out_t r;
    byte_tokens.delete();
    pr_fault = 1'b0;
    if (pr_drop) begin
      if (d.last_char) pr_drop = 1'b0;
      return;
    end
    scan_char(d.ch);
    if (pr_fault) begin
      pr_drop = !d.last_char;
    end else if (d.last_char) begin
      // Flush whatever is pending, then the end token unless the flush raised an error.
      case (pr_mode)
        MODE_IDENT:  close_word();
        MODE_NUMBER: close_number();
        MODE_SYMBOL: close_symbol();
        default:     clear_token();
      endcase
      if (!pr_fault) add_sym(KIND_END);
      clear_token();
    end
    if (byte_tokens.size() > 0) begin
      r             = byte_tokens.pop_back();
      r.last_result = 1'b1;
      byte_tokens.push_back(r);
    end
  endfunction

  function automatic void reset_predictor();
    clear_token();
    foreach (pr_chars[i]) pr_chars[i] = '0;
    pr_drop  = 1'b0;
    pr_fault = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor and token checker, both sampled at the rising edge.
  // ---------------------------------------------------------------------------
  int err_cnt    = 0;
  int bytes_in   = 0;
  int tokens_out = 0;
  int error_toks = 0;
  int texts_sent = 0;

  function automatic void check_field(string nm, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", nm, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    bit   typed;
    out_t fixed;
    out_t want;
    if (rst_n && byte_valid && !byte_stall) begin
      // Predict first; the typed token, where given, stands in for the prediction.
      typed = typed_flag_q.pop_front();
      fixed = typed_tok_q.pop_front();
      predict_tokens(byte_data);
      bytes_in++;
      if (typed) tokens_due.push_back(fixed);
      else foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
    end
    if (rst_n && tok_valid && !tok_stall) begin
      tokens_out++;
      if (tok_data.error_code != ERR_NONE) error_toks++;
      if (tokens_due.size() == 0) begin
        $error("token with nothing expected: kind %0d, error %0d",
               tok_data.token_kind, tok_data.error_code);
        err_cnt++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind",   64'(want.token_kind),   64'(tok_data.token_kind));
        check_field("number_value", 64'(want.number_value), 64'(tok_data.number_value));
        check_field("name_low",     want.name_low,          tok_data.name_low);
        check_field("name_high",    64'(want.name_high),    64'(tok_data.name_high));
        check_field("name_length",  64'(want.name_length),  64'(tok_data.name_length));
        check_field("error_code",   64'(want.error_code),   64'(tok_data.error_code));
        check_field("last_result",  64'(want.last_result),  64'(tok_data.last_result));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall at recv_pct, or a long hold-off when requested.
  // The hold-off is counted here; the stimulus side only bumps hold_reqs.
  // ---------------------------------------------------------------------------
  int send_pct  = 0;
  int recv_pct  = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      tok_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Every call starts and ends at a falling edge, so valid gets one
  // assignment per step and stays high across back-to-back transfers.
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] c, logic fin, bit typed, out_t fixed);
    typed_flag_q.push_back(typed);
    typed_tok_q.push_back(fixed);
    while ($urandom_range(99) < send_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{ch: c, last_char: fin};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, then hold until every owed token has come out.
  task automatic drain_tokens();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random text: mostly well-formed tokens with random content, some noise.
  // ---------------------------------------------------------------------------
  logic [7:0] text_q [$];

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? "a" : "A";
    return base + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(4))
      0:       return " ";
      1:       return 8'h09;
      2:       return $urandom_range(1) ? 8'h0A : 8'h0D;
      3:       return 8'($urandom_range(8'h20, 8'h01));
      default: return 8'h7F;
    endcase
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void build_text();
    int pick;
    int len;
    int ntok;
    text_q.delete();
    ntok = $urandom_range(12, 1);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        push_text(kw_text[$urandom_range(NUM_KEYWORDS - 1)]);
      end else if (pick < 38) begin
        // Identifier; now and then one character too many.
        len = ($urandom_range(19) == 0) ? MAX_IDENT_CHARS + 1
                                         : $urandom_range(MAX_IDENT_CHARS, 1);
        text_q.push_back(rand_letter());
        for (int i = 1; i < len; i++)
          text_q.push_back($urandom_range(2) ? rand_letter() : rand_digit());
      end else if (pick < 52) begin
        // Number: short, full width of nines, too long, or run into a letter.
        len = ($urandom_range(19) == 0) ? MAX_DIGITS + 1 : $urandom_range(MAX_DIGITS, 1);
        if ($urandom_range(15) == 0) begin
          for (int i = 0; i < MAX_DIGITS; i++) text_q.push_back("9");
        end else begin
          for (int i = 0; i < len; i++) text_q.push_back(rand_digit());
        end
        if ($urandom_range(29) == 0) text_q.push_back(rand_letter());
      end else if (pick < 75) begin
        push_text(sym_text[$urandom_range(NUM_SYMBOLS - 1)]);
      end else if (pick < 82) begin
        push_text("//");
        len = $urandom_range(6);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(255, 1);
          text_q.push_back((pick == 8'h0A || pick == 8'h0D) ? "x" : 8'(pick));
        end
        if ($urandom_range(3) != 0) text_q.push_back($urandom_range(1) ? 8'h0A : 8'h0D);
      end else if (pick < 88) begin
        text_q.push_back(rand_blank());
      end else begin
        text_q.push_back(8'($urandom_range(255, 1)));
      end
      if ($urandom_range(9) < 7) text_q.push_back(rand_blank());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Run: reset, directed table, then random phases under varied idling.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    out_t fixed;
    int   sent;
    reset_predictor();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: typed rows carry their one token with last_result set.
    for (int i = 0; i < NUM_PROBES; i++) begin
      fixed             = '0;
      fixed.token_kind  = PROBE_TAB[i].kind;
      fixed.error_code  = PROBE_TAB[i].err;
      fixed.last_result = 1'b1;
      send_byte(PROBE_TAB[i].ch, PROBE_TAB[i].fin, PROBE_TAB[i].typed, fixed);
    end
    drain_tokens();

    // Phases: no idling, sender idle, receiver stall, both, then a long
    // receiver hold-off while the sender keeps offering bytes.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_pct = 0;  recv_pct <= 0;  end
        1: begin send_pct = 49; recv_pct <= 0;  end
        2: begin send_pct = 0;  recv_pct <= 49; end
        3: begin send_pct = 22; recv_pct <= 22; end
        default: begin
          send_pct   = 0;
          recv_pct  <= 0;
          hold_reqs <= hold_reqs + 1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
        sent += text_q.size();
        texts_sent++;
      end
      drain_tokens();
    end

    // Let the pipeline settle, then report.
    repeat (16) @(posedge clk);
    $display("Run covered %0d source bytes (%0d random texts) and checked %0d tokens,",
             bytes_in, texts_sent, tokens_out);
    $display("%0d of them error tokens, under five idling and back-pressure phases.",
             error_toks);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && !byte_stall) || (tok_valid && !tok_stall)) quiet = 0;
      else quiet++;
    end
    $error("no transfer for %0d cycles, %0d tokens still owed", STALL_LIMIT,
           tokens_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
